// File: hw/rtl/kbs_pkg.sv
// Package for the kinematic bicycle step block.
// Holds fixed-point constants, the arctangent table, datapath op codes and the
// command and status structs shared by the controller and the datapath.
package kbs_pkg;

    // Widths of the internal number formats.
    localparam int ANG_W  = 36;  // angles and CORDIC vector, Q2.30 with headroom
    localparam int SD_W   = 33;  // speed times time step
    localparam int PROD_W = ANG_W + SD_W;
    localparam int DIV_W  = 31;  // dividend and quotient of the serial divider
    localparam int REM_W  = 17;  // partial remainder
    localparam int DVS_W  = 16;  // divisor
    localparam int IDX_W  = 5;   // iteration index
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMESTEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_H  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_V  = 3'd5;

    // Angle constants in Q2.30 radians.
    localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 36'sd652032874;

    // Heading wrap in Q3.13, and a bias of whole periods that keeps the
    // wrap dividend positive.
    localparam logic [DVS_W-1:0] HEAD_PERIOD = 16'd51472;
    localparam logic signed [DIV_W+1:0] HEAD_HALF = 33'sd25736;
    localparam logic signed [DIV_W+1:0] HEAD_BIAS = 33'sd843317248;

    // Reciprocal of the heading period, floor(2^47 / 51472). The estimated
    // quotient is exact or one too small for any 31-bit dividend.
    localparam logic [31:0] WRAP_RECIP = 32'd2734253348;
    localparam int WRAP_SHIFT = 47;
    localparam int WRAP_Q_W   = 16;

    localparam int DIV_STEPS = DIV_W;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_RESTART,
        OP_ROT_STEER_INIT,
        OP_ROT_HEAD_INIT,
        OP_ROT_ITER,
        OP_STEER_DONE,
        OP_VEC_ITER,
        OP_HEAD_TRIG_DONE,
        OP_MUL_SD,
        OP_MUL_X,
        OP_MUL_Y,
        OP_MUL_H,
        OP_QDIV_INIT,
        OP_DIV_ITER,
        OP_WRAP_MUL,
        OP_WRAP_SUB,
        OP_HEAD_DONE,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        logic                 load;
        op_t                  op;
        logic [IDX_W-1:0]     idx;
    } cmd_t;

    typedef struct packed {
        logic restart;
    } sts_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] z;
        logic                    neg;
    } rot_prep_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            5'd0:  r = 36'sd843314857;
            5'd1:  r = 36'sd497837829;
            5'd2:  r = 36'sd263043837;
            5'd3:  r = 36'sd133525159;
            5'd4:  r = 36'sd67021687;
            5'd5:  r = 36'sd33543516;
            5'd6:  r = 36'sd16775851;
            5'd7:  r = 36'sd8388437;
            5'd8:  r = 36'sd4194283;
            5'd9:  r = 36'sd2097149;
            5'd10: r = 36'sd1048576;
            5'd11: r = 36'sd524288;
            5'd12: r = 36'sd262144;
            5'd13: r = 36'sd131072;
            5'd14: r = 36'sd65536;
            5'd15: r = 36'sd32768;
            5'd16: r = 36'sd16384;
            5'd17: r = 36'sd8192;
            5'd18: r = 36'sd4096;
            5'd19: r = 36'sd2048;
            5'd20: r = 36'sd1024;
            5'd21: r = 36'sd512;
            5'd22: r = 36'sd256;
            5'd23: r = 36'sd128;
            5'd24: r = 36'sd64;
            5'd25: r = 36'sd32;
            5'd26: r = 36'sd16;
            5'd27: r = 36'sd8;
            5'd28: r = 36'sd4;
            5'd29: r = 36'sd2;
            5'd30: r = 36'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Wrap once into [-pi, pi), then fold into [-pi/2, pi/2].
    function automatic rot_prep_t rot_prep(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] w;
        rot_prep_t r;
        w = a;
        if (w >= ANG_PI)
            w = w - ANG_TWO_PI;
        if (w < -ANG_PI)
            w = w + ANG_TWO_PI;
        r.neg = 1'b0;
        if (w > ANG_HALF_PI)
        begin
            w = w - ANG_PI;
            r.neg = 1'b1;
        end
        else if (w < -ANG_HALF_PI)
        begin
            w = w + ANG_PI;
            r.neg = 1'b1;
        end
        r.z = w;
        return r;
    endfunction

endpackage

// File: hw/rtl/kbs_ctrl.sv
// Controller of the kinematic bicycle step block.
// Sequences the CORDIC runs, multiplies, the division and the heading wrap; uses kbs_pkg.
module kbs_ctrl
    import kbs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_RESTART, ST_R1_INIT, ST_R1_ITER, ST_R1_DONE,
        ST_VEC_ITER, ST_R2_INIT, ST_R2_ITER, ST_R2_DONE, ST_MUL_SD, ST_MUL_X,
        ST_MUL_Y, ST_MUL_H, ST_QDIV_INIT, ST_DIVQ_ITER, ST_WRAP_MUL,
        ST_WRAP_SUB, ST_HEAD_DONE, ST_PUBLISH
    } state_t;

    localparam logic [IDX_W-1:0] CORDIC_LAST = IDX_W'(CORDIC_STEPS - 1);
    localparam logic [IDX_W-1:0] DIV_LAST    = IDX_W'(DIV_STEPS - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             publish;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign publish  = (state_reg == ST_PUBLISH) && (!out_valid_reg || m_tready);

    // Command decode from the current state.
    always_comb
    begin
        cmd.load = s_tvalid && (state_reg == ST_IDLE);
        cmd.idx  = cnt_reg;
        unique case (state_reg)
            ST_RESTART:   cmd.op = OP_RESTART;
            ST_R1_INIT:   cmd.op = OP_ROT_STEER_INIT;
            ST_R1_ITER:   cmd.op = OP_ROT_ITER;
            ST_R1_DONE:   cmd.op = OP_STEER_DONE;
            ST_VEC_ITER:  cmd.op = OP_VEC_ITER;
            ST_R2_INIT:   cmd.op = OP_ROT_HEAD_INIT;
            ST_R2_ITER:   cmd.op = OP_ROT_ITER;
            ST_R2_DONE:   cmd.op = OP_HEAD_TRIG_DONE;
            ST_MUL_SD:    cmd.op = OP_MUL_SD;
            ST_MUL_X:     cmd.op = OP_MUL_X;
            ST_MUL_Y:     cmd.op = OP_MUL_Y;
            ST_MUL_H:     cmd.op = OP_MUL_H;
            ST_QDIV_INIT: cmd.op = OP_QDIV_INIT;
            ST_DIVQ_ITER: cmd.op = OP_DIV_ITER;
            ST_WRAP_MUL:  cmd.op = OP_WRAP_MUL;
            ST_WRAP_SUB:  cmd.op = OP_WRAP_SUB;
            ST_HEAD_DONE: cmd.op = OP_HEAD_DONE;
            ST_PUBLISH:   cmd.op = publish ? OP_PUBLISH : OP_IDLE;
            default:      cmd.op = OP_IDLE;
        endcase
    end

    // State, iteration counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            unique case (state_reg)
                ST_IDLE:      if (s_tvalid) state_reg <= ST_DECODE;
                ST_DECODE:    state_reg <= sts.restart ? ST_RESTART : ST_R1_INIT;
                ST_RESTART:   state_reg <= ST_WRAP_MUL;
                ST_R1_INIT:   state_reg <= ST_R1_ITER;
                ST_R1_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CORDIC_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_R1_DONE;
                    end
                end
                ST_R1_DONE:   state_reg <= ST_VEC_ITER;
                ST_VEC_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CORDIC_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_R2_INIT;
                    end
                end
                ST_R2_INIT:   state_reg <= ST_R2_ITER;
                ST_R2_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CORDIC_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_R2_DONE;
                    end
                end
                ST_R2_DONE:   state_reg <= ST_MUL_SD;
                ST_MUL_SD:    state_reg <= ST_MUL_X;
                ST_MUL_X:     state_reg <= ST_MUL_Y;
                ST_MUL_Y:     state_reg <= ST_MUL_H;
                ST_MUL_H:     state_reg <= ST_QDIV_INIT;
                ST_QDIV_INIT: state_reg <= ST_DIVQ_ITER;
                ST_DIVQ_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_WRAP_MUL;
                    end
                end
                ST_WRAP_MUL:  state_reg <= ST_WRAP_SUB;
                ST_WRAP_SUB:  state_reg <= ST_HEAD_DONE;
                ST_HEAD_DONE: state_reg <= ST_PUBLISH;
                ST_PUBLISH:
                begin
                    if (publish)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/kbs_datapath.sv
// Datapath of the kinematic bicycle step block: configuration registers,
// vehicle state, shared CORDIC, multipliers and a serial divider; uses kbs_pkg.
module kbs_datapath
    import kbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    input  logic                  in_command,
    input  logic signed [14:0]    in_steer,
    input  logic signed [15:0]    in_accel,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic [95:0]           out_data
);

    // Configuration registers.
    logic [15:0]        len_reg, dt_reg;
    logic signed [31:0] sx_reg, sy_reg;
    logic signed [15:0] sh_cfg_reg, sv_cfg_reg;

    // Vehicle state.
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [15:0] heading_reg, speed_reg;

    // Latched item.
    logic               restart_reg;
    logic signed [14:0] steer_reg;
    logic signed [15:0] accel_reg;

    // CORDIC, products and divider.
    logic signed [ANG_W-1:0]  x_reg, y_reg, z_reg;
    logic                     neg_reg;
    logic signed [ANG_W-1:0]  ss_reg, ch_reg, shd_reg;
    logic signed [SD_W-1:0]   sd_reg, ad_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DIV_W-1:0]         quo_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DVS_W-1:0]         dvs_reg;
    logic                     qneg_reg;
    logic [DIV_W-1:0]         wrap_x_reg;
    logic [95:0]              out_reg;

    logic [15:0]              len_eff;
    logic signed [ANG_W-1:0]  xs, ys, atan_i, c_fin, s_fin;
    logic signed [ANG_W-1:0]  steer_ang, head_ang;
    rot_prep_t                prep_steer, prep_head;
    logic [REM_W:0]           trial;
    logic signed [PROD_W-1:0] rnd;
    logic signed [33:0]       pos_sum;
    logic signed [31:0]       pos_new;
    logic signed [16:0]       spd_delta;
    logic signed [17:0]       spd_sum;
    logic signed [15:0]       spd_new;
    logic [PROD_W-2:0]        mag;
    logic [63:0]              qa;
    logic signed [DIV_W+1:0]  hdiv, rdiv, qsigned;
    logic [DIV_W-1:0]         wrap_src;
    logic [WRAP_Q_W-1:0]      wrap_q;
    logic [31:0]              wrap_qd;
    logic [REM_W-1:0]         wrap_r;

    assign sts.restart = restart_reg;
    assign out_data    = out_reg;
    assign len_eff     = (len_reg == '0) ? 16'd1 : len_reg;

    // CORDIC helpers.
    assign xs        = x_reg >>> cmd.idx;
    assign ys        = y_reg >>> cmd.idx;
    assign atan_i    = atan_lut(cmd.idx);
    assign c_fin     = neg_reg ? -x_reg : x_reg;
    assign s_fin     = neg_reg ? -y_reg : y_reg;
    assign steer_ang = ANG_W'(steer_reg) <<< 17;
    assign head_ang  = (ANG_W'(heading_reg) <<< 17) + z_reg;
    assign prep_steer = rot_prep(steer_ang);
    assign prep_head  = rot_prep(head_ang);

    // Divider step: one quotient bit a cycle.
    assign trial = {rem_reg, quo_reg[DIV_W-1]} - {2'b00, dvs_reg};

    // Heading wrap by reciprocal multiply: the estimated quotient is exact or
    // one short, so one conditional subtract finishes the remainder.
    assign wrap_src = restart_reg ? rdiv[DIV_W-1:0] : hdiv[DIV_W-1:0];
    assign wrap_q   = prod_reg[WRAP_SHIFT+WRAP_Q_W-1:WRAP_SHIFT];
    assign wrap_qd  = 32'(wrap_q) * 32'(HEAD_PERIOD);
    assign wrap_r   = (rem_reg >= REM_W'(HEAD_PERIOD)) ? rem_reg - REM_W'(HEAD_PERIOD)
                                                       : rem_reg;

    // Position update: round half up at bit 38, then saturate.
    always_comb
    begin
        rnd     = (prod_reg + (PROD_W'(1) <<< 37)) >>> 38;
        pos_sum = (cmd.op == OP_MUL_Y) ? 34'(pos_x_reg) : 34'(pos_y_reg);
        pos_sum = pos_sum + 34'($signed(rnd[31:0]));
        if (pos_sum > 34'sd2147483647)
            pos_new = 32'sh7FFFFFFF;
        else if (pos_sum < -34'sd2147483648)
            pos_new = 32'sh80000000;
        else
            pos_new = pos_sum[31:0];
    end

    // Speed update: round half up at bit 16, then saturate.
    always_comb
    begin
        spd_delta = 17'((ad_reg + 33'sd32768) >>> 16);
        spd_sum   = 18'(speed_reg) + 18'(spd_delta);
        if (spd_sum > 18'sd32767)
            spd_new = 16'sh7FFF;
        else if (spd_sum < -18'sd32768)
            spd_new = 16'sh8000;
        else
            spd_new = spd_sum[15:0];
    end

    // Heading quotient dividend and wrap dividends.
    always_comb
    begin
        mag     = prod_reg[PROD_W-1] ? (PROD_W-1)'(-prod_reg) : prod_reg[PROD_W-2:0];
        qa      = 64'(mag) + ({48'd0, len_eff} << 32);
        qsigned = qneg_reg ? -(DIV_W+2)'({1'b0, quo_reg}) : (DIV_W+2)'({1'b0, quo_reg});
        hdiv    = (DIV_W+2)'(heading_reg) + qsigned + HEAD_HALF + HEAD_BIAS;
        rdiv    = (DIV_W+2)'(sh_cfg_reg) + HEAD_HALF + HEAD_BIAS;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= 16'd1152;
            dt_reg     <= 16'd6554;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sh_cfg_reg <= '0;
            sv_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LENGTH:   len_reg    <= cfg_data[15:0];
                REG_TIMESTEP: dt_reg     <= cfg_data[15:0];
                REG_START_X:  sx_reg     <= cfg_data;
                REG_START_Y:  sy_reg     <= cfg_data;
                REG_START_H:  sh_cfg_reg <= cfg_data[15:0];
                REG_START_V:  sv_cfg_reg <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Vehicle state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
            speed_reg   <= '0;
            restart_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                restart_reg <= in_command;
            unique case (cmd.op)
                OP_RESTART:
                begin
                    pos_x_reg <= sx_reg;
                    pos_y_reg <= sy_reg;
                    speed_reg <= sv_cfg_reg;
                end
                OP_MUL_X:     speed_reg   <= spd_new;
                OP_MUL_Y:     pos_x_reg   <= pos_new;
                OP_MUL_H:     pos_y_reg   <= pos_new;
                OP_HEAD_DONE: heading_reg <= 16'(33'({16'd0, wrap_r}) - HEAD_HALF);
                default:      ;
            endcase
        end
    end

    // Working registers of the shared units.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            steer_reg <= in_steer;
            accel_reg <= in_accel;
        end
        unique case (cmd.op)
            OP_ROT_STEER_INIT:
            begin
                x_reg   <= CORDIC_GAIN;
                y_reg   <= '0;
                z_reg   <= prep_steer.z;
                neg_reg <= prep_steer.neg;
            end
            OP_ROT_HEAD_INIT:
            begin
                x_reg   <= CORDIC_GAIN;
                y_reg   <= '0;
                z_reg   <= prep_head.z;
                neg_reg <= prep_head.neg;
            end
            OP_ROT_ITER:
            begin
                if (!z_reg[ANG_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_i;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_i;
                end
            end
            OP_STEER_DONE:
            begin
                ss_reg <= s_fin;
                z_reg  <= '0;
                if (c_fin[ANG_W-1])
                begin
                    x_reg <= -(c_fin <<< 1);
                    y_reg <= -s_fin;
                end
                else
                begin
                    x_reg <= c_fin <<< 1;
                    y_reg <= s_fin;
                end
            end
            OP_VEC_ITER:
            begin
                if (y_reg[ANG_W-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_i;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_i;
                end
            end
            OP_HEAD_TRIG_DONE:
            begin
                ch_reg  <= c_fin;
                shd_reg <= s_fin;
            end
            OP_MUL_SD:
            begin
                sd_reg <= SD_W'(speed_reg) * $signed({1'b0, dt_reg});
                ad_reg <= SD_W'(accel_reg) * $signed({1'b0, dt_reg});
            end
            OP_MUL_X:     prod_reg <= PROD_W'(sd_reg) * PROD_W'(ch_reg);
            OP_MUL_Y:     prod_reg <= PROD_W'(sd_reg) * PROD_W'(shd_reg);
            OP_MUL_H:     prod_reg <= PROD_W'(sd_reg) * PROD_W'(ss_reg);
            OP_QDIV_INIT:
            begin
                quo_reg  <= qa[63:33];
                rem_reg  <= '0;
                dvs_reg  <= len_eff;
                qneg_reg <= prod_reg[PROD_W-1];
            end
            OP_DIV_ITER:
            begin
                if (!trial[REM_W])
                begin
                    rem_reg <= trial[REM_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[REM_W-2:0], quo_reg[DIV_W-1]};
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
            end
            OP_WRAP_MUL:
            begin
                wrap_x_reg <= wrap_src;
                prod_reg   <= PROD_W'(64'(wrap_src) * 64'(WRAP_RECIP));
            end
            OP_WRAP_SUB:  rem_reg <= REM_W'(32'(wrap_x_reg) - wrap_qd);
            OP_PUBLISH:   out_reg <= {speed_reg, heading_reg, pos_y_reg, pos_x_reg};
            default:      ;
        endcase
    end

endmodule

// File: hw/rtl/kinematic_bicycle_step.sv
// Top level of the kinematic bicycle step block.
// Joins kbs_ctrl and kbs_datapath; uses kbs_pkg.
//
// Channel  Direction  Beat contents
// s_*      in         tdata: steering_angle[14:0], acceleration[30:15]; tuser: command
// m_*      out        tdata: out_x, out_y, out_heading, out_speed
// cfg_*    in         one register write per cycle, no read-back
//
// A step beat passes from accept to result through three CORDIC runs that share
// one unit, a serial division by the length that gives the heading change, and
// a reciprocal multiply that wraps the heading. A restart beat skips the CORDIC
// runs, multiplies and division and goes straight to the heading wrap.
// Reset clears the state and loads the register defaults. A new beat is taken
// once the previous result sits in the output register, even if it is stalled.
module kinematic_bicycle_step
    import kbs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // steering_angle, acceleration, pad bit
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,   // out_x, out_y, out_heading, out_speed
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    kbs_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    kbs_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_command (s_tuser),
        .in_steer   ($signed(s_tdata[14:0])),
        .in_accel   ($signed(s_tdata[30:15])),
        .cmd        (cmd),
        .sts        (sts),
        .out_data   (m_tdata)
    );

endmodule

// File: bench/kinematic_bicycle_step_tb.sv
// Testbench for the kinematic bicycle step block.
// Self-checking: a predictor computes each expected state, a monitor compares beats.
// Depends on kbs_pkg and kinematic_bicycle_step.
`timescale 1ns / 1ps

module kinematic_bicycle_step_tb;
    import kbs_pkg::*;

    localparam int STEPS = 16;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint HEAD_HALF_LSB = 64'sd25736;
    localparam longint HEAD_PERIOD_LSB = 64'sd51472;
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic        restart;
        logic [14:0] steer;
        logic [15:0] accel;
    } motion_cmd_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic [15:0] speed;
    } vehicle_state_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;   // steering_angle[14:0], acceleration[30:15], zero pad
    logic s_tuser;          // command
    logic m_tvalid;
    logic m_tready;
    logic [95:0] m_tdata;   // out_x, out_y, out_heading, out_speed
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Predictor copies of registers and vehicle state.
    longint len_reg, dt_reg, sx_reg, sy_reg, sh_reg, sv_reg;
    longint px, py, hd, sp;

    motion_cmd_t pending_cmds[$];
    vehicle_state_t expected_states[$];
    int mismatches;
    bit no_idle;

    kinematic_bicycle_step #(.CORDIC_STEPS(STEPS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic longint atan_q30(input int i);
        longint t[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
            262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
        return t[i];
    endfunction

    // Flooring right shift.
    function automatic longint shr_floor(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap_head(input longint h);
        longint r;
        r = (h + HEAD_HALF_LSB) % HEAD_PERIOD_LSB;
        if (r < 0)
            r += HEAD_PERIOD_LSB;
        return r - HEAD_HALF_LSB;
    endfunction

    // Rotation CORDIC giving cosine and sine in Q2.30.
    task automatic rotate_angle(input longint a, output longint c, output longint s);
        longint x, y, t;
        bit flip;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (a >= PI_Q30)
            a -= TWO_PI_Q30;
        if (a < -PI_Q30)
            a += TWO_PI_Q30;
        if (a > HALF_PI_Q30)
        begin
            a -= PI_Q30;
            flip = 1;
        end
        else if (a < -HALF_PI_Q30)
        begin
            a += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (a >= 0)
            begin
                t = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                a -= atan_q30(i);
            end
            else
            begin
                t = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                a += atan_q30(i);
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Vectoring CORDIC giving the angle of (x, y).
    function automatic longint vector_angle(input longint x, input longint y);
        longint z, t;
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (y < 0)
            begin
                t = x - shr_floor(y, i);
                y = y + shr_floor(x, i);
                z -= atan_q30(i);
            end
            else
            begin
                t = x + shr_floor(y, i);
                y = y - shr_floor(x, i);
                z += atan_q30(i);
            end
            x = t;
        end
        return z;
    endfunction

    // Advance the predicted vehicle state by one command.
    task automatic advance_vehicle(input motion_cmd_t c);
        longint steer, acc, len, cs, ss, ch, sh, slip, num, den, mag, dh;
        vehicle_state_t st;
        if (c.restart == CMD_RESTART)
        begin
            px = sx_reg;
            py = sy_reg;
            hd = wrap_head(sh_reg);
            sp = sv_reg;
        end
        else
        begin
            steer = longint'($signed(c.steer)) * 131072;
            acc = longint'($signed(c.accel));
            len = (len_reg == 0) ? 1 : len_reg;
            rotate_angle(steer, cs, ss);
            if (cs < 0)
                slip = vector_angle(-2 * cs, -ss);
            else
                slip = vector_angle(2 * cs, ss);
            rotate_angle(hd * 131072 + slip, ch, sh);
            num = sp * ss * dt_reg;
            den = len <<< 33;
            mag = num < 0 ? -num : num;
            dh = (mag + den / 2) / den;
            if (num < 0)
                dh = -dh;
            px = clamp(px + round_shift(sp * ch * dt_reg, 38), -64'sd2147483648, 64'sd2147483647);
            py = clamp(py + round_shift(sp * sh * dt_reg, 38), -64'sd2147483648, 64'sd2147483647);
            hd = wrap_head(hd + dh);
            sp = clamp(sp + round_shift(acc * dt_reg, 16), -64'sd32768, 64'sd32767);
        end
        st.x = px[31:0];
        st.y = py[31:0];
        st.heading = hd[15:0];
        st.speed = sp[15:0];
        expected_states.push_back(st);
    endtask

    // Clock.
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Driver: presents queued commands, predicts on each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata <= '0;
            s_tuser <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                advance_vehicle({s_tuser, s_tdata[14:0], s_tdata[30:15]});
            if ((!s_tvalid || s_tready) && !(s_tvalid && !s_tready))
            begin
                if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 19))
                begin
                    motion_cmd_t c;
                    c = pending_cmds.pop_front();
                    s_tvalid <= 1;
                    s_tuser <= c.restart;
                    s_tdata <= {1'b0, c.accel, c.steer};
                end
                else
                    s_tvalid <= 0;
            end
        end
    end

    // Monitor: ready with random stalls, compares each beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_states.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result beat %h", m_tdata);
                end
                else
                begin
                    vehicle_state_t e;
                    e = expected_states.pop_front();
                    if (m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y ||
                        m_tdata[79:64] !== e.heading || m_tdata[95:80] !== e.speed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: x %h/%h y %h/%h head %h/%h speed %h/%h",
                                e.x, m_tdata[31:0], e.y, m_tdata[63:32],
                                e.heading, m_tdata[79:64], e.speed, m_tdata[95:80]);
                    end
                end
            end
            m_tready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val[31:0];
        case (idx)
            REG_LENGTH:   len_reg = val & 16'hFFFF;
            REG_TIMESTEP: dt_reg = val & 16'hFFFF;
            REG_START_X:  sx_reg = longint'($signed(val[31:0]));
            REG_START_Y:  sy_reg = longint'($signed(val[31:0]));
            REG_START_H:  sh_reg = longint'($signed(val[15:0]));
            default:      sv_reg = longint'($signed(val[15:0]));
        endcase
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Let queued commands drain and results arrive.
    task automatic drain_all();
        while (pending_cmds.size() > 0 || s_tvalid || expected_states.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic motion_cmd_t rand_step(input bit wide);
        motion_cmd_t c;
        c.restart = CMD_STEP;
        c.steer = wide ? 15'($urandom) : 15'($signed($urandom_range(25736)) - 12868);
        c.accel = 16'($urandom);
        return c;
    endfunction

    task automatic add_cmd(input logic r, input longint st, input longint ac);
        motion_cmd_t c;
        c.restart = r;
        c.steer = st[14:0];
        c.accel = ac[15:0];
        pending_cmds.push_back(c);
    endtask

    // Stimulus.
    initial
    begin
        longint v;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        no_idle = 0;
        len_reg = 1152; dt_reg = 6554; sx_reg = 0; sy_reg = 0; sh_reg = 0; sv_reg = 0;
        px = 0; py = 0; hd = 0; sp = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // Directed: extremes of steering and acceleration, restarts, wrap.
        add_cmd(CMD_STEP, 0, 32767);
        add_cmd(CMD_STEP, 12868, 32767);
        add_cmd(CMD_STEP, -12868, -32768);
        add_cmd(CMD_STEP, 16383, 0);
        add_cmd(CMD_STEP, -16384, 100);
        add_cmd(CMD_STEP, 6000, -1);
        drain_all();
        write_reg(REG_START_X, 64'h7FFF_FF00);
        write_reg(REG_START_Y, 64'h8000_0100);
        write_reg(REG_START_H, 16'h8000);
        write_reg(REG_START_V, 16'h7FFF);
        add_cmd(CMD_RESTART, 0, 0);
        add_cmd(CMD_STEP, 1000, 32767);
        add_cmd(CMD_STEP, -3000, 32767);
        add_cmd(CMD_STEP, 12868, -32768);
        drain_all();
        write_reg(REG_LENGTH, 0);
        write_reg(REG_TIMESTEP, 65535);
        write_reg(REG_START_H, 25735);
        write_reg(REG_START_V, 16'h8000);
        add_cmd(CMD_RESTART, 0, 0);
        add_cmd(CMD_STEP, 12868, -32768);
        add_cmd(CMD_STEP, -12868, 32767);
        add_cmd(CMD_STEP, 0, 0);
        drain_all();
        write_reg(REG_TIMESTEP, 0);
        add_cmd(CMD_STEP, 7000, 5000);
        drain_all();

        // Random phases with varying configuration.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_LENGTH, ph == 1 ? 1 : (ph == 2 ? 65535 : $urandom_range(65535)));
            write_reg(REG_TIMESTEP, ph == 3 ? 65535 : (ph == 4 ? 1 : $urandom_range(65535)));
            write_reg(REG_START_X, $urandom);
            write_reg(REG_START_Y, $urandom);
            v = $urandom_range(51471);
            write_reg(REG_START_H, (ph == 5) ? 16'($urandom) : v - 25736);
            write_reg(REG_START_V, $urandom);
            no_idle = (ph == 2);
            for (int k = 0; k < 250; k++)
            begin
                if ($urandom_range(99) < 5)
                    add_cmd(CMD_RESTART, $urandom, $urandom);
                else
                    pending_cmds.push_back(rand_step($urandom_range(99) < 15));
            end
            drain_all();
        end
        no_idle = 0;

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(64'd20_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
